@@ src/tlmc_pkg.sv @@
// Shared types, constants and register indexes of the traffic light mode controller.
package tlmc_pkg;

	// Brightness sample resolution; the sample port stays 10 bits wide
	localparam int ADC_BITS      = 10;
	// Length of one slot of the flash phase in ms
	localparam int FLASH_SLOT_MS = 100;

	localparam int CYCLE_W  = 13;
	localparam int GAP_W    = 10;
	localparam int LEVEL_W  = 10;
	localparam int DRIVE_W  = 8;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 3;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	localparam logic [GAP_W-1:0] GAP_MAX = '1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CYCLE_LENGTH  = 3'd0,
		REG_RED_END       = 3'd1,
		REG_YELLOW_END    = 3'd2,
		REG_GREEN_END     = 3'd3,
		REG_FLASH_END     = 3'd4,
		REG_EDGE_DEBOUNCE = 3'd5,
		REG_POLL_DEBOUNCE = 3'd6,
		REG_BLINK_HALF    = 3'd7
	} reg_idx_t;

	// Status codes on the result
	typedef enum logic [STATUS_W-1:0] {
		ST_OFF       = 3'd0,
		ST_EMERGENCY = 3'd1,
		ST_BLINKING  = 3'd2,
		ST_RED       = 3'd3,
		ST_YELLOW    = 3'd4,
		ST_GREEN     = 3'd5,
		ST_FLASH     = 3'd6
	} status_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] cycle_length_ms;
		logic [CYCLE_W-1:0] red_end_ms;
		logic [CYCLE_W-1:0] first_yellow_end_ms;
		logic [CYCLE_W-1:0] green_end_ms;
		logic [CYCLE_W-1:0] flash_end_ms;
		logic [GAP_W-1:0]   edge_debounce_ms;
		logic [GAP_W-1:0]   poll_debounce_ms;
		logic [GAP_W-1:0]   blink_half_period_ms;
	} cfg_t;

	// One tick request after the input register
	typedef struct packed {
		logic [LEVEL_W-1:0] light_level;
		logic               blink_button;
		logic               power_button;
		logic               emergency_button;
	} tick_t;

	// Mode flags after this tick's toggles
	typedef struct packed {
		logic off;
		logic emergency;
		logic blinking;
	} mode_t;

	// Timer values seen by the current tick
	typedef struct packed {
		logic [CYCLE_W-1:0] cycle_ms;
		logic               blink_lit;
	} timer_t;

	typedef struct packed {
		status_t            status_code;
		logic [DRIVE_W-1:0] flash_drive;
		logic [DRIVE_W-1:0] green_drive;
		logic [DRIVE_W-1:0] yellow_drive;
		logic [DRIVE_W-1:0] red_drive;
	} result_t;

endpackage

@@ src/tlmc_mode.sv @@
// Button edge detection, debounce gap counters and mode flags.
module tlmc_mode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  tlmc_pkg::tick_t tick,
	input  tlmc_pkg::cfg_t  cfg,
	output tlmc_pkg::mode_t mode
);
	import tlmc_pkg::*;

	logic [2:0]       prev_levels_q;
	logic [2:0]       levels;
	logic [2:0]       fall;
	logic             acc_e, acc_p, acc_b;
	logic             off_q, emergency_q, blinking_q;
	logic [GAP_W-1:0] since_e_q, since_p_q, since_b_q;

	// Detect falling edges and apply the debounce gaps
	assign levels = {tick.blink_button, tick.power_button, tick.emergency_button};
	assign fall   = prev_levels_q & ~levels;
	assign acc_e  = fall[0] && (since_e_q >= cfg.edge_debounce_ms);
	assign acc_p  = fall[1] && (since_p_q >= cfg.edge_debounce_ms);
	assign acc_b  = fall[2] && (since_b_q > cfg.poll_debounce_ms);

	// Flags as seen by this tick's outputs
	assign mode.off       = off_q ^ acc_p;
	assign mode.emergency = emergency_q ^ acc_e;
	assign mode.blinking  = blinking_q ^ acc_b;

	function automatic logic [GAP_W-1:0] bump(input logic [GAP_W-1:0] gap, input logic acc);
		if (acc)
			return GAP_W'(1);
		return (gap == GAP_MAX) ? GAP_MAX : gap + GAP_W'(1);
	endfunction

	// Commit flags and gaps once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= 3'b111;
			off_q         <= 1'b0;
			emergency_q   <= 1'b0;
			blinking_q    <= 1'b0;
			since_e_q     <= '0;
			since_p_q     <= '0;
			since_b_q     <= '0;
		end else if (step) begin
			prev_levels_q <= levels;
			off_q         <= mode.off;
			emergency_q   <= mode.emergency;
			blinking_q    <= mode.blinking;
			since_e_q     <= bump(since_e_q, acc_e);
			since_p_q     <= bump(since_p_q, acc_p);
			since_b_q     <= bump(since_b_q, acc_b);
		end
	end

endmodule

@@ src/tlmc_timer.sv @@
// Normal cycle position and panel blink timers.
module tlmc_timer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  tlmc_pkg::cfg_t   cfg,
	output tlmc_pkg::timer_t timer
);
	import tlmc_pkg::*;

	logic [CYCLE_W-1:0] cycle_q;
	logic [GAP_W-1:0]   blink_q;
	logic               lit_q;
	logic [CYCLE_W:0]   cycle_next;
	logic [GAP_W:0]     blink_next;
	logic               cycle_wrap;
	logic               blink_wrap;

	assign timer.cycle_ms  = cycle_q;
	assign timer.blink_lit = lit_q;

	// Wrap when the next position reaches the length; zero length wraps naturally
	assign cycle_next = {1'b0, cycle_q} + (CYCLE_W+1)'(1);
	assign cycle_wrap = (cfg.cycle_length_ms != '0) &&
		(cycle_next >= {1'b0, cfg.cycle_length_ms});
	assign blink_next = {1'b0, blink_q} + (GAP_W+1)'(1);
	assign blink_wrap = blink_next >= {1'b0, cfg.blink_half_period_ms};

	// Advance both timers once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= '0;
			blink_q <= '0;
			lit_q   <= 1'b1;
		end else if (step) begin
			cycle_q <= cycle_wrap ? '0 : cycle_next[CYCLE_W-1:0];
			if (blink_wrap) begin
				blink_q <= '0;
				lit_q   <= ~lit_q;
			end else begin
				blink_q <= blink_next[GAP_W-1:0];
			end
		end
	end

endmodule

@@ src/tlmc_drive.sv @@
// Brightness scaling, phase selection and LED drive values.
module tlmc_drive (
	input  tlmc_pkg::tick_t   tick,
	input  tlmc_pkg::cfg_t    cfg,
	input  tlmc_pkg::mode_t   mode,
	input  tlmc_pkg::timer_t  timer,
	output tlmc_pkg::result_t result
);
	import tlmc_pkg::*;

	localparam int PROD_W = LEVEL_W + DRIVE_W + 1;
	localparam logic [PROD_W-1:0] FULL     = PROD_W'((1 << ADC_BITS) - 1);
	localparam logic [PROD_W-1:0] DRV_MAX  = PROD_W'(255);
	localparam logic [CYCLE_W:0]  SLOT_1   = (CYCLE_W+1)'(FLASH_SLOT_MS);
	localparam logic [CYCLE_W:0]  SLOT_3   = (CYCLE_W+1)'(3 * FLASH_SLOT_MS);
	localparam logic [CYCLE_W:0]  SLOT_4   = (CYCLE_W+1)'(4 * FLASH_SLOT_MS);
	localparam logic [CYCLE_W:0]  SLOT_6   = (CYCLE_W+1)'(6 * FLASH_SLOT_MS);
	localparam logic [CYCLE_W:0]  SLOT_7   = (CYCLE_W+1)'(7 * FLASH_SLOT_MS);

	logic [PROD_W-1:0]  prod, q0, rem, quot;
	logic [DRIVE_W-1:0] bright;
	logic [CYCLE_W:0]   flash_pos;
	logic               flash_lit;
	logic [CYCLE_W-1:0] pos;

	// Divide by 2^ADC_BITS-1: shift estimate plus one correction step
	assign prod = PROD_W'(tick.light_level) * PROD_W'(255);
	assign q0   = prod >> ADC_BITS;
	assign rem  = (prod & FULL) + q0;
	assign quot = (q0 >= DRV_MAX) ? DRV_MAX : q0 + PROD_W'(rem >= FULL);
	assign bright = quot[DRIVE_W-1:0];

	// Flash phase is lit in slots 0, 3 and 6
	assign pos       = timer.cycle_ms;
	assign flash_pos = {1'b0, pos - cfg.green_end_ms};
	assign flash_lit = (flash_pos < SLOT_1) ||
		((flash_pos >= SLOT_3) && (flash_pos < SLOT_4)) ||
		((flash_pos >= SLOT_6) && (flash_pos < SLOT_7));

	// Pick the shown mode in priority order
	always_comb begin
		result = '0;
		result.status_code = ST_OFF;
		priority if (mode.off) begin
			result.status_code = ST_OFF;
		end else if (mode.emergency) begin
			result.status_code = ST_EMERGENCY;
			result.red_drive   = bright;
		end else if (mode.blinking) begin
			result.status_code = ST_BLINKING;
			if (timer.blink_lit) begin
				result.red_drive    = bright;
				result.yellow_drive = bright;
				result.green_drive  = bright;
				result.flash_drive  = bright;
			end
		end else if (pos < cfg.red_end_ms) begin
			result.status_code = ST_RED;
			result.red_drive   = bright;
		end else if (pos < cfg.first_yellow_end_ms) begin
			result.status_code  = ST_YELLOW;
			result.yellow_drive = bright;
		end else if (pos < cfg.green_end_ms) begin
			result.status_code = ST_GREEN;
			result.green_drive = bright;
		end else if (pos < cfg.flash_end_ms) begin
			result.status_code = ST_FLASH;
			if (flash_lit)
				result.flash_drive = bright;
		end else begin
			result.status_code  = ST_YELLOW;
			result.yellow_drive = bright;
		end
	end

endmodule

@@ src/traffic_light_mode_controller_core.sv @@
// Top level of the traffic light mode controller: registers, handshake and config.
//
// Usage: each request on the s_ channel is one millisecond tick carrying the
// three active-low button levels and a brightness sample. Every tick yields
// exactly one result on the m_ channel: four LED drive values and a status
// code. Configuration registers are written through cfg_we/cfg_index/cfg_data
// while no tick is in flight; a write takes effect at the next edge.
// Path: an accepted request is captured in the input register, and its result
// is then shown on m_tdata from the result register. Throughput: one tick per
// cycle while m_tready stays high; all per-tick work is a short path from the
// input register to the result register, and mode flags and timers commit as
// the tick enters the result register.
// Stall: when m_tready is low the result holds, one more request may wait in
// the input register, and s_tready then drops until the result is taken.
// Reset: arst_n clears both valid stages, the timers, the debounce gaps and
// the mode flags, and loads the default register values; no clearing pass.
module traffic_light_mode_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// emergency_button[0], power_button[1], blink_button[2], light_level[12:3]
	input  logic [tlmc_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// red_drive[7:0], yellow_drive[15:8], green_drive[23:16], flash_drive[31:24],
	// status_code[34:32]
	output logic [tlmc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [tlmc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tlmc_pkg::CFG_W-1:0]          cfg_data
);
	import tlmc_pkg::*;

	cfg_t    cfg_q;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    step;
	mode_t   mode;
	timer_t  timer;
	result_t result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_length_ms      <= CYCLE_W'(6000);
			cfg_q.red_end_ms           <= CYCLE_W'(2000);
			cfg_q.first_yellow_end_ms  <= CYCLE_W'(2500);
			cfg_q.green_end_ms         <= CYCLE_W'(4500);
			cfg_q.flash_end_ms         <= CYCLE_W'(5500);
			cfg_q.edge_debounce_ms     <= GAP_W'(200);
			cfg_q.poll_debounce_ms     <= GAP_W'(50);
			cfg_q.blink_half_period_ms <= GAP_W'(500);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CYCLE_LENGTH:  cfg_q.cycle_length_ms      <= cfg_data;
				REG_RED_END:       cfg_q.red_end_ms           <= cfg_data;
				REG_YELLOW_END:    cfg_q.first_yellow_end_ms  <= cfg_data;
				REG_GREEN_END:     cfg_q.green_end_ms         <= cfg_data;
				REG_FLASH_END:     cfg_q.flash_end_ms         <= cfg_data;
				REG_EDGE_DEBOUNCE: cfg_q.edge_debounce_ms     <= cfg_data[GAP_W-1:0];
				REG_POLL_DEBOUNCE: cfg_q.poll_debounce_ms     <= cfg_data[GAP_W-1:0];
				REG_BLINK_HALF:    cfg_q.blink_half_period_ms <= cfg_data[GAP_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Move the held request on when the result register is free or drains
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_t'(s_tdata[LEVEL_W+2:0]);
		end
	end

	tlmc_mode u_mode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.mode   (mode)
	);

	tlmc_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.timer  (timer)
	);

	tlmc_drive u_drive (
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.mode   (mode),
		.timer  (timer),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, result_s2};

	// A held request is never dropped while the result stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held request lost during stall");

	// A new result only appears from a held request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a request");

	// Off shows all LEDs dark
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.status_code == ST_OFF |->
		result_s2.red_drive == '0 && result_s2.yellow_drive == '0 &&
		result_s2.green_drive == '0 && result_s2.flash_drive == '0)
		else $error("LED lit while off");

	// Emergency drives red only
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.status_code == ST_EMERGENCY |->
		result_s2.yellow_drive == '0 && result_s2.green_drive == '0 &&
		result_s2.flash_drive == '0)
		else $error("non-red LED lit in emergency");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the traffic light mode controller core: tick stream in, LED drives out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tlmc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SHOWN_ERRORS = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// Pending tick requests and the LED results they must produce
	tick_t   ticks_pending[$];
	result_t lights_due[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int lights_checked = 0;
	int cycle_count    = 0;
	int status_seen [7];

	// Controller copy: registers, timers, debounce gaps and mode flags
	logic [CFG_W-1:0]   ctrl_reg [8];
	logic [CYCLE_W-1:0] cycle_ms;
	logic [GAP_W-1:0]   blink_ms;
	logic               blink_lit;
	logic               mode_off, mode_emergency, mode_blinking;
	logic [GAP_W-1:0]   gap_emergency, gap_power, gap_blink;
	logic [2:0]         prev_levels;

	traffic_light_mode_controller_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timed out after %0d cycles, %0d results still due", cycle_count,
				lights_due.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		if (mismatches < SHOWN_ERRORS)
			$display("[%0t] result %0d: %s", $realtime, lights_checked, msg);
		mismatches++;
	endtask

	function automatic logic [GAP_W-1:0] bump_gap(input logic [GAP_W-1:0] gap, input logic taken);
		if (taken)
			return GAP_W'(1);
		return (gap == GAP_MAX) ? GAP_MAX : gap + 1'b1;
	endfunction

	// Apply one tick: toggles first, then lights from the new flags, then advance timers
	task automatic advance_controller(input tick_t t);
		logic        fall_e, fall_p, fall_b, acc_e, acc_p, acc_b;
		int unsigned bright, slot, nxt;
		result_t     r;
		fall_e = prev_levels[0] && !t.emergency_button;
		fall_p = prev_levels[1] && !t.power_button;
		fall_b = prev_levels[2] && !t.blink_button;
		acc_e  = fall_e && (gap_emergency >= ctrl_reg[REG_EDGE_DEBOUNCE][GAP_W-1:0]);
		acc_p  = fall_p && (gap_power >= ctrl_reg[REG_EDGE_DEBOUNCE][GAP_W-1:0]);
		acc_b  = fall_b && (gap_blink > ctrl_reg[REG_POLL_DEBOUNCE][GAP_W-1:0]);
		if (acc_e) mode_emergency = !mode_emergency;
		if (acc_p) mode_off = !mode_off;
		if (acc_b) mode_blinking = !mode_blinking;
		gap_emergency = bump_gap(gap_emergency, acc_e);
		gap_power     = bump_gap(gap_power, acc_p);
		gap_blink     = bump_gap(gap_blink, acc_b);
		prev_levels   = {t.blink_button, t.power_button, t.emergency_button};

		bright = (int'(t.light_level) * 255) / ((1 << ADC_BITS) - 1);
		if (bright > 255)
			bright = 255;

		r = '0;
		if (mode_off) begin
			r.status_code = ST_OFF;
		end else if (mode_emergency) begin
			r.status_code = ST_EMERGENCY;
			r.red_drive   = bright[7:0];
		end else if (mode_blinking) begin
			r.status_code = ST_BLINKING;
			if (blink_lit) begin
				r.red_drive    = bright[7:0];
				r.yellow_drive = bright[7:0];
				r.green_drive  = bright[7:0];
				r.flash_drive  = bright[7:0];
			end
		end else if (cycle_ms < ctrl_reg[REG_RED_END]) begin
			r.status_code = ST_RED;
			r.red_drive   = bright[7:0];
		end else if (cycle_ms < ctrl_reg[REG_YELLOW_END]) begin
			r.status_code  = ST_YELLOW;
			r.yellow_drive = bright[7:0];
		end else if (cycle_ms < ctrl_reg[REG_GREEN_END]) begin
			r.status_code = ST_GREEN;
			r.green_drive = bright[7:0];
		end else if (cycle_ms < ctrl_reg[REG_FLASH_END]) begin
			// lit only in the first, fourth and seventh slot of the flash phase
			slot = (int'(cycle_ms) - int'(ctrl_reg[REG_GREEN_END])) / FLASH_SLOT_MS;
			r.status_code = ST_FLASH;
			if (slot == 0 || slot == 3 || slot == 6)
				r.flash_drive = bright[7:0];
		end else begin
			r.status_code  = ST_YELLOW;
			r.yellow_drive = bright[7:0];
		end

		// wrap the cycle at its length; a zero length wraps at the counter width
		nxt = int'(cycle_ms) + 1;
		if (ctrl_reg[REG_CYCLE_LENGTH] != 0 && nxt >= int'(ctrl_reg[REG_CYCLE_LENGTH]))
			nxt = 0;
		cycle_ms = nxt[CYCLE_W-1:0];

		nxt = int'(blink_ms) + 1;
		if (nxt >= int'(ctrl_reg[REG_BLINK_HALF][GAP_W-1:0])) begin
			blink_ms  = '0;
			blink_lit = !blink_lit;
		end else begin
			blink_ms = nxt[GAP_W-1:0];
		end

		lights_due.push_back(r);
	endtask

	task automatic check_lights(input result_t got);
		result_t want;
		if (lights_due.size() == 0) begin
			report_error($sformatf("result 0x%0h with no tick outstanding", got));
		end else begin
			want = lights_due.pop_front();
			if (got.red_drive !== want.red_drive)
				report_error($sformatf("red_drive got %0d want %0d",
					got.red_drive, want.red_drive));
			if (got.yellow_drive !== want.yellow_drive)
				report_error($sformatf("yellow_drive got %0d want %0d",
					got.yellow_drive, want.yellow_drive));
			if (got.green_drive !== want.green_drive)
				report_error($sformatf("green_drive got %0d want %0d",
					got.green_drive, want.green_drive));
			if (got.flash_drive !== want.flash_drive)
				report_error($sformatf("flash_drive got %0d want %0d",
					got.flash_drive, want.flash_drive));
			if (got.status_code !== want.status_code)
				report_error($sformatf("status_code got %0d want %0d",
					got.status_code, want.status_code));
		end
		if (got.status_code <= ST_FLASH)
			status_seen[got.status_code]++;
		lights_checked++;
	endtask

	// Drive tick requests from the pending queue; predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				advance_controller(tick_t'(s_tdata[$bits(tick_t)-1:0]));
			if (!s_tvalid || s_tready) begin
				if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= IN_TDATA_W'(ticks_pending.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Take results and stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_lights(result_t'(m_tdata[$bits(result_t)-1:0]));
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic tick_t make_tick(input logic [2:0] levels, input logic [LEVEL_W-1:0] sample);
		make_tick.emergency_button = levels[0];
		make_tick.power_button     = levels[1];
		make_tick.blink_button     = levels[2];
		make_tick.light_level      = sample;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		ctrl_reg[idx] = (idx >= REG_EDGE_DEBOUNCE) ? CFG_W'(val[GAP_W-1:0]) : val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Order: cycle length, red, yellow, green, flash ends, edge and poll debounce, blink half
	task automatic apply_setting(input int unsigned vals [8]);
		for (int i = 0; i < 8; i++)
			write_reg(reg_idx_t'(i), vals[i]);
	endtask

	task automatic set_pacing(input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (ticks_pending.size() != 0 || s_tvalid || lights_due.size() != 0);
	endtask

	// Press/release sequences per button with random brightness, plus some noise
	task automatic queue_random(input int count, input int press_pct);
		logic [2:0]         lv;
		logic [LEVEL_W-1:0] sample;
		lv = 3'b111;
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				lv = 3'($urandom);
			end else begin
				for (int b = 0; b < 3; b++) begin
					if (lv[b])
						lv[b] = !($urandom_range(99) < press_pct);
					else
						lv[b] = ($urandom_range(99) < 40);
				end
			end
			if ($urandom_range(4) == 0)
				sample = LEVEL_W'(($urandom_range(1) == 1) ? 1023 - $urandom_range(1)
					: $urandom_range(1));
			else
				sample = LEVEL_W'($urandom);
			ticks_pending.push_back(make_tick(lv, sample));
		end
	endtask

	// Toggle every set mode flag back off; needs both debounce registers at zero
	task automatic clear_modes();
		ticks_pending.push_back(make_tick(3'b111, 10'd700));
		if (mode_off) begin
			ticks_pending.push_back(make_tick(3'b101, 10'd700));
			ticks_pending.push_back(make_tick(3'b111, 10'd700));
		end
		if (mode_emergency) begin
			ticks_pending.push_back(make_tick(3'b110, 10'd700));
			ticks_pending.push_back(make_tick(3'b111, 10'd700));
		end
		if (mode_blinking) begin
			ticks_pending.push_back(make_tick(3'b011, 10'd700));
			ticks_pending.push_back(make_tick(3'b111, 10'd700));
		end
		wait_drained();
	endtask

	initial begin
		logic [2:0]         press_seq [24];
		logic [LEVEL_W-1:0] corner_samples [6];
		int                 flash_ticks;

		// Power-on register values and state
		ctrl_reg[REG_CYCLE_LENGTH]  = 13'd6000;
		ctrl_reg[REG_RED_END]       = 13'd2000;
		ctrl_reg[REG_YELLOW_END]    = 13'd2500;
		ctrl_reg[REG_GREEN_END]     = 13'd4500;
		ctrl_reg[REG_FLASH_END]     = 13'd5500;
		ctrl_reg[REG_EDGE_DEBOUNCE] = 13'd200;
		ctrl_reg[REG_POLL_DEBOUNCE] = 13'd50;
		ctrl_reg[REG_BLINK_HALF]    = 13'd500;
		cycle_ms       = '0;
		blink_ms       = '0;
		blink_lit      = 1'b1;
		mode_off       = 1'b0;
		mode_emergency = 1'b0;
		mode_blinking  = 1'b0;
		gap_emergency  = '0;
		gap_power      = '0;
		gap_blink      = '0;
		prev_levels    = 3'b111;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Debounce edges at gaps of 2 and 3 ticks, zero blink half period, sample corners
		set_pacing(0, 0);
		apply_setting('{0, 2, 4, 6, 10, 3, 2, 0});
		press_seq = '{3'd7, 3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd7, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7,
			3'd5, 3'd7, 3'd5, 3'd7, 3'd7, 3'd5, 3'd3, 3'd7, 3'd3, 3'd7, 3'd7, 3'd0};
		corner_samples = '{10'd1023, 10'd0, 10'd1, 10'd1022, 10'd512, 10'd341};
		for (int i = 0; i < 24; i++)
			ticks_pending.push_back(make_tick(press_seq[i], corner_samples[i % 6]));
		wait_drained();

		// Cycle length cut below the running count, all phase ends at maximum
		apply_setting('{1, 8191, 8191, 8191, 8191, 1, 0, 2});
		queue_random(40, 25);
		wait_drained();

		// Short wrapping cycle
		set_pacing(59, 0);
		apply_setting('{30, 10, 15, 20, 28, 2, 1, 3});
		queue_random(50, 15);
		wait_drained();

		// Ordered phases without wrap
		set_pacing(0, 59);
		apply_setting('{0, 50, 70, 100, 115, 20, 10, 7});
		queue_random(90, 12);
		wait_drained();

		// Empty yellow and flash phases from inverted ends
		set_pacing(26, 26);
		apply_setting('{0, 150, 140, 170, 160, 0, 0, 1});
		queue_random(50, 10);
		wait_drained();
		clear_modes();

		// Long flash phase through its seventh slot; maximum debounce rejects every press
		apply_setting('{0, 0, 0, 0, 8191, 1023, 1023, 1023});
		flash_ticks = (cycle_ms < 720) ? 720 - int'(cycle_ms) : 120;
		for (int chunk = 0; chunk < 4; chunk++) begin
			case (chunk)
				0: set_pacing(0, 0);
				1: set_pacing(59, 0);
				2: set_pacing(0, 59);
				default: set_pacing(26, 26);
			endcase
			queue_random(flash_ticks / 4 + 1, 10);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("%0d ticks checked over 6 register settings and 4 pacing mixes", lights_checked);
		$display("status seen: off %0d, emergency %0d, blinking %0d, red %0d, yellow %0d, green %0d, flash %0d",
			status_seen[ST_OFF], status_seen[ST_EMERGENCY], status_seen[ST_BLINKING],
			status_seen[ST_RED], status_seen[ST_YELLOW], status_seen[ST_GREEN],
			status_seen[ST_FLASH]);
		if (mismatches == 0 && lights_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ traffic_light_mode_controller_core.f @@
src/tlmc_pkg.sv
src/tlmc_mode.sv
src/tlmc_timer.sv
src/tlmc_drive.sv
src/traffic_light_mode_controller_core.sv
bench/testbench.sv
